// ===== design/dva_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the direction-vector-to-angles block.
// No dependencies; imported by every module of the block.
package dva_pkg;

  // Datapath width of the CORDIC x/y words (input scaled up to bit 59)
  localparam int DW        = 64;
  // Angle accumulator: degrees * 2^ACC_FRAC, signed
  localparam int ACC_FRAC  = 24;
  localparam int ACC_W     = 34;
  // Arctangent table depth
  localparam int TABLE_LEN = 24;
  // CORDIC gain compensation factor, Q14 (about 1.64676)
  localparam int GAIN_Q14  = 26981;
  localparam int GAIN_W    = 15;
  localparam int GAIN_FRAC = 14;
  // Result and configuration widths
  localparam int OUT_W     = 16;
  localparam int TOL_W     = 8;

  // Angles in whole degrees
  localparam int ANGLE_DOWN = 90;
  localparam int ANGLE_HALF = 180;
  localparam int ANGLE_UP   = 270;
  localparam int ANGLE_FULL = 360;

  typedef logic signed [DW-1:0]    dat_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t HALF_TURN_ACC = acc_t'(ANGLE_HALF) <<< ACC_FRAC;
  localparam acc_t FULL_TURN_ACC = acc_t'(ANGLE_FULL) <<< ACC_FRAC;

  // Special-case flags that ride along with each vector
  typedef struct packed {
    logic null_vec;  // all three components zero
    logic vert;      // |x| and |y| within tolerance
    logic z_pos;     // z > 0
  } flags_t;

  // atan(2^-i) in degrees * 2^24
  function automatic acc_t atan_deg(input int unsigned idx);
    acc_t val;
    unique case (idx)
      0:       val = acc_t'(754974720);
      1:       val = acc_t'(445687602);
      2:       val = acc_t'(235489089);
      3:       val = acc_t'(119537938);
      4:       val = acc_t'(60000934);
      5:       val = acc_t'(30029717);
      6:       val = acc_t'(15018523);
      7:       val = acc_t'(7509720);
      8:       val = acc_t'(3754917);
      9:       val = acc_t'(1877466);
      10:      val = acc_t'(938734);
      11:      val = acc_t'(469367);
      12:      val = acc_t'(234684);
      13:      val = acc_t'(117342);
      14:      val = acc_t'(58671);
      15:      val = acc_t'(29335);
      16:      val = acc_t'(14668);
      17:      val = acc_t'(7334);
      18:      val = acc_t'(3667);
      19:      val = acc_t'(1833);
      20:      val = acc_t'(917);
      21:      val = acc_t'(458);
      22:      val = acc_t'(229);
      23:      val = acc_t'(115);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== design/dva_front.sv =====
`timescale 1ns / 1ps
// Input register and pre-rotation stage: special-case detection, half-plane
// fold for the yaw pass and gain-compensated -z. Depends on dva_pkg.
module dva_front
  import dva_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  logic                                 valid_i,
  input  logic signed [COORD_WIDTH-1:0]        x_i,
  input  logic signed [COORD_WIDTH-1:0]        y_i,
  input  logic signed [COORD_WIDTH-1:0]        z_i,
  input  logic        [TOL_W-1:0]              tol_i,
  output logic                                 valid_o,
  output dat_t                                 x_o,
  output dat_t                                 y_o,
  output acc_t                                 acc_o,
  output logic signed [COORD_WIDTH+GAIN_W+1:0] nprod_o,
  output flags_t                               flags_o
);

  localparam int GUARD   = 60 - COORD_WIDTH;
  localparam int NPROD_W = COORD_WIDTH + GAIN_W + 2;
  localparam logic signed [NPROD_W-1:0] GAIN_S = NPROD_W'(GAIN_Q14);

  // Stage A: registered input
  logic                          a_valid_q;
  logic signed [COORD_WIDTH-1:0] a_x_q, a_y_q, a_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv_i) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_x_q <= x_i;
      a_y_q <= y_i;
      a_z_q <= z_i;
    end
  end

  // Stage B logic: scale, fold left half-plane, magnitudes, -z * gain
  dat_t                          xe, ye;
  logic signed [COORD_WIDTH:0]   xs, ys;
  logic        [COORD_WIDTH:0]   xmag, ymag, tol_ext;
  logic signed [NPROD_W-1:0]     zx;
  logic                          x_neg;

  assign x_neg   = a_x_q[COORD_WIDTH-1];
  assign xe      = dat_t'(a_x_q) <<< GUARD;
  assign ye      = dat_t'(a_y_q) <<< GUARD;
  assign xs      = (COORD_WIDTH+1)'(a_x_q);
  assign ys      = (COORD_WIDTH+1)'(a_y_q);
  assign xmag    = xs[COORD_WIDTH] ? $unsigned(-xs) : $unsigned(xs);
  assign ymag    = ys[COORD_WIDTH] ? $unsigned(-ys) : $unsigned(ys);
  assign tol_ext = (COORD_WIDTH+1)'(tol_i);
  assign zx      = NPROD_W'(a_z_q);

  logic                      b_valid_q;
  dat_t                      b_x_q, b_y_q;
  acc_t                      b_acc_q;
  logic signed [NPROD_W-1:0] b_nprod_q;
  flags_t                    b_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv_i) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b_x_q              <= x_neg ? -xe : xe;
      b_y_q              <= x_neg ? -ye : ye;
      b_acc_q            <= x_neg ? HALF_TURN_ACC : '0;
      b_nprod_q          <= (-zx) * GAIN_S;
      b_flags_q.null_vec <= (a_x_q == '0) && (a_y_q == '0) && (a_z_q == '0);
      b_flags_q.vert     <= (xmag <= tol_ext) && (ymag <= tol_ext);
      b_flags_q.z_pos    <= !a_z_q[COORD_WIDTH-1] && (a_z_q != '0);
    end
  end

  assign valid_o = b_valid_q;
  assign x_o     = b_x_q;
  assign y_o     = b_y_q;
  assign acc_o   = b_acc_q;
  assign nprod_o = b_nprod_q;
  assign flags_o = b_flags_q;

endmodule

// ===== design/dva_cordic_stage.sv =====
`timescale 1ns / 1ps
// One registered CORDIC vectoring iteration with a pass-through sideband.
// Depends on dva_pkg (datapath types and arctangent table).
module dva_cordic_stage
  import dva_pkg::*;
#(
  parameter int STAGE  = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              valid_i,
  input  dat_t              x_i,
  input  dat_t              y_i,
  input  acc_t              acc_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output dat_t              x_o,
  output dat_t              y_o,
  output acc_t              acc_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam acc_t ATAN = atan_deg(STAGE);

  // Rotate toward y = 0; arithmetic shifts floor like the spec
  dat_t dx, dy;
  logic y_neg;

  assign dx    = y_i >>> STAGE;
  assign dy    = x_i >>> STAGE;
  assign y_neg = y_i[DW-1];

  logic              valid_q;
  dat_t              x_q, y_q;
  acc_t              acc_q;
  logic [SIDE_W-1:0] side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q    <= y_neg ? x_i - dx : x_i + dx;
      y_q    <= y_neg ? y_i + dy : y_i - dy;
      acc_q  <= y_neg ? acc_i - ATAN : acc_i + ATAN;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign acc_o   = acc_q;
  assign side_o  = side_q;

endmodule

// ===== design/dva_back.sv =====
`timescale 1ns / 1ps
// Angle wrap, rounding, special-case override and output register with skid.
// Depends on dva_pkg (accumulator type, flags and angle constants).
module dva_back
  import dva_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  acc_t             pitch_acc_i,
  input  acc_t             yaw_acc_i,
  input  flags_t           flags_i,
  input  logic             ready_i,
  output logic             adv_o,
  output logic             valid_o,
  output logic [OUT_W-1:0] pitch_o,
  output logic [OUT_W-1:0] yaw_o,
  output logic             null_o
);

  localparam int SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int R_W   = ACC_W - SHIFT;
  localparam logic [ACC_W-1:0] RND = ACC_W'(1) << (SHIFT - 1);
  localparam logic [R_W-1:0]   LIM = R_W'(ANGLE_FULL) << ANGLE_FRAC_BITS;
  localparam logic [OUT_W-1:0] PITCH_UP   = OUT_W'(ANGLE_UP << ANGLE_FRAC_BITS);
  localparam logic [OUT_W-1:0] PITCH_DOWN = OUT_W'(ANGLE_DOWN << ANGLE_FRAC_BITS);

  typedef struct packed {
    logic [OUT_W-1:0] pitch;
    logic [OUT_W-1:0] yaw;
    logic             null_vec;
  } res_t;

  // Bring an angle into [0, 360)
  function automatic acc_t wrap_turn(input acc_t a);
    acc_t w;
    if (a < 0) begin
      w = a + FULL_TURN_ACC;
    end else if (a >= FULL_TURN_ACC) begin
      w = a - FULL_TURN_ACC;
    end else begin
      w = a;
    end
    return w;
  endfunction

  // Round half up to the output scale; 360 folds back to 0
  function automatic logic [OUT_W-1:0] round_deg(input acc_t w);
    logic [ACC_W-1:0] sum;
    logic [R_W-1:0]   r;
    sum = $unsigned(w) + RND;
    r   = sum[ACC_W-1:SHIFT];
    if (r >= LIM) begin
      r = r - LIM;
    end
    return OUT_W'(r);
  endfunction

  logic adv;

  // Wrap stage
  logic   f1_valid_q;
  acc_t   f1_pitch_q, f1_yaw_q;
  flags_t f1_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else if (adv) begin
      f1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_pitch_q <= wrap_turn(pitch_acc_i);
      f1_yaw_q   <= wrap_turn(yaw_acc_i);
      f1_flags_q <= flags_i;
    end
  end

  // Round and apply special cases
  res_t res;

  always_comb begin
    if (f1_flags_q.null_vec) begin
      res.pitch    = '0;
      res.yaw      = '0;
      res.null_vec = 1'b1;
    end else if (f1_flags_q.vert) begin
      res.pitch    = f1_flags_q.z_pos ? PITCH_UP : PITCH_DOWN;
      res.yaw      = '0;
      res.null_vec = 1'b0;
    end else begin
      res.pitch    = round_deg(f1_pitch_q);
      res.yaw      = round_deg(f1_yaw_q);
      res.null_vec = 1'b0;
    end
  end

  // Output register plus skid entry; the pipeline halts only when the skid is full
  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;
  logic push, pop;

  assign adv  = !skid_valid_q;
  assign push = adv && f1_valid_q;
  assign pop  = out_valid_q && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign adv_o   = adv;
  assign valid_o = out_valid_q;
  assign pitch_o = out_q.pitch;
  assign yaw_o   = out_q.yaw;
  assign null_o  = out_q.null_vec;

  // The skid entry is only ever used behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while output register empty");

  // A result arriving at a stalled output lands in the skid entry
  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !ready_i && push) |=> skid_valid_q)
    else $error("result arriving at stalled output was dropped");

  // A null vector always reports zero angles
  a_null_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.null_vec) |-> (out_q.pitch == '0 && out_q.yaw == '0))
    else $error("null vector with nonzero angle");

endmodule

// ===== design/direction_vector_to_angles.sv =====
`timescale 1ns / 1ps
// Direction vector to pitch/yaw angles. Registers from input transaction to result:
// input register, pre-rotation, CORDIC_STAGES yaw iterations, CORDIC_STAGES
// pitch iterations, wrap, round into the output register. Throughput: one
// transaction per cycle while the skid entry is empty; a skid entry behind the
// output keeps tready registered. Reset clears all valid bits and null_tolerance
// to 0. Depends on dva_pkg and the dva_* modules.
module direction_vector_to_angles
  import dva_pkg::*;
#(
  parameter int COORD_WIDTH     = 16,
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // Configuration: null_tolerance
  input  logic                                       cfg_we_i,
  input  logic [TOL_W-1:0]                           cfg_wdata_i,
  // Input vectors
  input  logic                                       s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  // x_coord, y_coord, z_coord (COORD_WIDTH each), zero pad to bytes
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]         s_axis_tdata_i,
  // Results
  output logic                                       m_axis_tvalid_o,
  input  logic                                       m_axis_tready_i,
  // pitch_deg [15:0], yaw_deg [31:16]
  output logic [2*OUT_W-1:0]                         m_axis_tdata_o,
  // null_vector
  output logic                                       m_axis_tuser_o
);

  localparam int GUARD   = 60 - COORD_WIDTH;
  localparam int NPROD_W = COORD_WIDTH + GAIN_W + 2;
  localparam int FL_W    = $bits(flags_t);
  localparam int YS_W    = FL_W + NPROD_W;
  localparam int PS_W    = FL_W + ACC_W;
  localparam int N       = CORDIC_STAGES;

  // Configuration register
  logic [TOL_W-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  logic adv;
  assign s_axis_tready_o = adv;

  // Front end
  logic                      f_valid;
  dat_t                      f_x, f_y;
  acc_t                      f_acc;
  logic signed [NPROD_W-1:0] f_nprod;
  flags_t                    f_flags;

  dva_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s_axis_tvalid_i),
    .x_i     (s_axis_tdata_i[COORD_WIDTH-1:0]),
    .y_i     (s_axis_tdata_i[2*COORD_WIDTH-1:COORD_WIDTH]),
    .z_i     (s_axis_tdata_i[3*COORD_WIDTH-1:2*COORD_WIDTH]),
    .tol_i   (tol_q),
    .valid_o (f_valid),
    .x_o     (f_x),
    .y_o     (f_y),
    .acc_o   (f_acc),
    .nprod_o (f_nprod),
    .flags_o (f_flags)
  );

  // Yaw pass: vector (x, y) onto the x axis
  logic            yv   [N+1];
  dat_t            yx   [N+1];
  dat_t            yy   [N];
  acc_t            yacc [N+1];
  logic [YS_W-1:0] yside[N+1];

  assign yv[0]    = f_valid;
  assign yx[0]    = f_x;
  assign yy[0]    = f_y;
  assign yacc[0]  = f_acc;
  assign yside[0] = {f_flags, f_nprod};

  for (genvar g = 0; g < N; g++) begin : g_yaw
    if (g < N - 1) begin : g_mid
      dva_cordic_stage #(.STAGE(g), .SIDE_W(YS_W)) u_stage (
        .clk_i (clk_i), .rst_ni (rst_ni), .adv_i (adv),
        .valid_i (yv[g]), .x_i (yx[g]), .y_i (yy[g]), .acc_i (yacc[g]),
        .side_i (yside[g]),
        .valid_o (yv[g+1]), .x_o (yx[g+1]), .y_o (yy[g+1]), .acc_o (yacc[g+1]),
        .side_o (yside[g+1])
      );
    end else begin : g_last
      dva_cordic_stage #(.STAGE(g), .SIDE_W(YS_W)) u_stage (
        .clk_i (clk_i), .rst_ni (rst_ni), .adv_i (adv),
        .valid_i (yv[g]), .x_i (yx[g]), .y_i (yy[g]), .acc_i (yacc[g]),
        .side_i (yside[g]),
        .valid_o (yv[g+1]), .x_o (yx[g+1]), .y_o (), .acc_o (yacc[g+1]),
        .side_o (yside[g+1])
      );
    end
  end

  // Pitch pass: vector (gain * xy length, -gain * z)
  flags_t                    y_flags;
  logic signed [NPROD_W-1:0] y_nprod;

  assign y_flags = flags_t'(yside[N][YS_W-1 -: FL_W]);
  assign y_nprod = $signed(yside[N][NPROD_W-1:0]);

  logic            pv   [N+1];
  dat_t            px   [N];
  dat_t            py   [N];
  acc_t            pacc [N+1];
  logic [PS_W-1:0] pside[N+1];

  assign pv[0]    = yv[N];
  assign px[0]    = yx[N];
  assign py[0]    = dat_t'(y_nprod) <<< (GUARD - GAIN_FRAC);
  assign pacc[0]  = '0;
  assign pside[0] = {y_flags, yacc[N]};

  for (genvar g = 0; g < N; g++) begin : g_pitch
    if (g < N - 1) begin : g_mid
      dva_cordic_stage #(.STAGE(g), .SIDE_W(PS_W)) u_stage (
        .clk_i (clk_i), .rst_ni (rst_ni), .adv_i (adv),
        .valid_i (pv[g]), .x_i (px[g]), .y_i (py[g]), .acc_i (pacc[g]),
        .side_i (pside[g]),
        .valid_o (pv[g+1]), .x_o (px[g+1]), .y_o (py[g+1]), .acc_o (pacc[g+1]),
        .side_o (pside[g+1])
      );
    end else begin : g_last
      dva_cordic_stage #(.STAGE(g), .SIDE_W(PS_W)) u_stage (
        .clk_i (clk_i), .rst_ni (rst_ni), .adv_i (adv),
        .valid_i (pv[g]), .x_i (px[g]), .y_i (py[g]), .acc_i (pacc[g]),
        .side_i (pside[g]),
        .valid_o (pv[g+1]), .x_o (), .y_o (), .acc_o (pacc[g+1]),
        .side_o (pside[g+1])
      );
    end
  end

  // Back end
  logic [OUT_W-1:0] pitch, yaw;

  dva_back #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (pv[N]),
    .pitch_acc_i (pacc[N]),
    .yaw_acc_i   (acc_t'(pside[N][ACC_W-1:0])),
    .flags_i     (flags_t'(pside[N][PS_W-1 -: FL_W])),
    .ready_i     (m_axis_tready_i),
    .adv_o       (adv),
    .valid_o     (m_axis_tvalid_o),
    .pitch_o     (pitch),
    .yaw_o       (yaw),
    .null_o      (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {yaw, pitch};

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for direction_vector_to_angles: predicts pitch, yaw and the
// null flag for every vector transaction and compares each result in order.
// Depends on dva_pkg and the direction_vector_to_angles RTL.
module tb_top;
  import dva_pkg::*;

  localparam int COORD_WIDTH     = 16;
  localparam int CORDIC_STAGES   = 16;
  localparam int ANGLE_FRAC_BITS = 7;
  // Inputs are scaled so the top coordinate bit lands at bit 59
  localparam int GUARD           = 60 - COORD_WIDTH;
  localparam int DRAIN_CYCLES    = 2 * CORDIC_STAGES + 10;

  // atan(2^-i) in degrees * 2^24
  localparam longint ARCTAN_Q24 [TABLE_LEN] = '{
    754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic [OUT_W-1:0] pitch;
    logic [OUT_W-1:0] yaw;
    logic             null_vec;
  } angles_t;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   cfg_we_i        = 1'b0;
  logic [TOL_W-1:0]       cfg_wdata_i     = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [3*COORD_WIDTH-1:0] s_axis_tdata_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [2*OUT_W-1:0]     m_axis_tdata_o;
  logic                   m_axis_tuser_o;

  // Predictor copy of null_tolerance
  logic [TOL_W-1:0] tolerance = '0;
  angles_t          expected_angles[$];
  int               mismatch_count = 0;
  int               sink_stall     = 0;
  bit               no_idling      = 1'b0;

  always #6 clk_i = ~clk_i;

  direction_vector_to_angles #(
    .COORD_WIDTH    (COORD_WIDTH),
    .CORDIC_STAGES  (CORDIC_STAGES),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // ---------------------------------------------------------------------------
  // Angle predictor
  // ---------------------------------------------------------------------------

  // Vectoring rotation: drives vy toward zero, returns the angle turned
  function automatic longint cordic_vectoring(inout longint vx, inout longint vy);
    longint ax, ay, dx, dy, angle;
    ax    = vx;
    ay    = vy;
    angle = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = ay >>> i;
      dy = ax >>> i;
      if (ay >= 0) begin
        ax    = ax + dx;
        ay    = ay - dy;
        angle = angle + ARCTAN_Q24[i];
      end else begin
        ax    = ax - dx;
        ay    = ay + dy;
        angle = angle - ARCTAN_Q24[i];
      end
    end
    vx = ax;
    vy = ay;
    return angle;
  endfunction

  // Wrap into [0,360), round half up, fold a rounded 360 back to 0
  function automatic logic [OUT_W-1:0] angle_to_code(input longint acc_in);
    longint acc, full_turn, wrap_lim, r;
    acc       = acc_in;
    full_turn = longint'(ANGLE_FULL) <<< ACC_FRAC;
    wrap_lim  = longint'(ANGLE_FULL) <<< ANGLE_FRAC_BITS;
    if (acc < 0) acc = acc + full_turn;
    if (acc >= full_turn) acc = acc - full_turn;
    r = (acc + (longint'(1) <<< (ACC_FRAC - 1 - ANGLE_FRAC_BITS)))
        >>> (ACC_FRAC - ANGLE_FRAC_BITS);
    if (r >= wrap_lim) r = r - wrap_lim;
    return r[OUT_W-1:0];
  endfunction

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic angles_t predict_angles(input coord_t x_in, input coord_t y_in,
                                             input coord_t z_in);
    longint  x, y, z, cx, cy, px, py, yaw_acc, pitch_acc;
    angles_t res;
    x   = x_in;
    y   = y_in;
    z   = z_in;
    res = '0;
    if (x == 0 && y == 0 && z == 0) begin
      res.null_vec = 1'b1;
      return res;
    end
    // Vertical: yaw forced to 0, pitch straight up or down
    if (magnitude(x) <= longint'(tolerance) && magnitude(y) <= longint'(tolerance)) begin
      res.pitch = OUT_W'((z > 0 ? ANGLE_UP : ANGLE_DOWN) << ANGLE_FRAC_BITS);
      return res;
    end
    cx      = x * (longint'(1) <<< GUARD);
    cy      = y * (longint'(1) <<< GUARD);
    yaw_acc = 0;
    // Left half-plane: pre-rotate by 180 degrees
    if (cx < 0) begin
      cx      = -cx;
      cy      = -cy;
      yaw_acc = longint'(ANGLE_HALF) <<< ACC_FRAC;
    end
    yaw_acc   = yaw_acc + cordic_vectoring(cx, cy);
    px        = cx;
    py        = -(z * GAIN_Q14) * (longint'(1) <<< (GUARD - GAIN_FRAC));
    pitch_acc = cordic_vectoring(px, py);
    res.yaw   = angle_to_code(yaw_acc);
    res.pitch = angle_to_code(pitch_acc);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle gaps: mostly short, a few long
  // ---------------------------------------------------------------------------
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result-side back-pressure
  always @(posedge clk_i) begin
    if (sink_stall > 0) begin
      m_axis_tready_i <= 1'b0;
      sink_stall = sink_stall - 1;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (!no_idling && $urandom_range(0, 3) == 0) sink_stall = gap_length();
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    angles_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_angles.size() == 0) begin
        mismatch_count++;
        $error("result transaction with no expected angles: tdata=%h tuser=%b",
               m_axis_tdata_o, m_axis_tuser_o);
      end else begin
        want = expected_angles.pop_front();
        if (m_axis_tdata_o[OUT_W-1:0] !== want.pitch) begin
          mismatch_count++;
          $error("pitch_deg: expected %0d, actual %0d", want.pitch,
                 m_axis_tdata_o[OUT_W-1:0]);
        end
        if (m_axis_tdata_o[2*OUT_W-1:OUT_W] !== want.yaw) begin
          mismatch_count++;
          $error("yaw_deg: expected %0d, actual %0d", want.yaw,
                 m_axis_tdata_o[2*OUT_W-1:OUT_W]);
        end
        if (m_axis_tuser_o !== want.null_vec) begin
          mismatch_count++;
          $error("null_vector: expected %0b, actual %0b", want.null_vec,
                 m_axis_tuser_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One vector transaction; tvalid stays high so back-to-back sends need no gap
  task automatic send_vector(input coord_t x, input coord_t y, input coord_t z);
    int gap;
    gap = no_idling ? 0 : (($urandom_range(0, 99) < 30) ? gap_length() : 0);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {z, y, x};
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_angles.push_back(predict_angles(x, y, z));
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic await_idle();
    s_axis_tvalid_i <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    await_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    tolerance = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic coord_t coord_sample();
    int     r;
    coord_t v;
    r = $urandom_range(0, 9);
    if (r < 5) return coord_t'($urandom);
    if (r < 8) return coord_t'($signed($urandom_range(0, 600)) - 300);
    if (r == 8) begin
      case ($urandom_range(0, 4))
        0:       v = coord_t'(-32768);
        1:       v = coord_t'(32767);
        2:       v = coord_t'(-1);
        3:       v = coord_t'(1);
        default: v = '0;
      endcase
      return v;
    end
    // Right at or just past the tolerance edge
    v = coord_t'(int'(tolerance) + int'($urandom_range(0, 1)));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Zero vector and unit axes at reset tolerance (0)
  task automatic test_null_and_axes();
    send_vector(16'sd0, 16'sd0, 16'sd0);
    send_vector(16'sd1, 16'sd0, 16'sd0);
    send_vector(-16'sd1, 16'sd0, 16'sd0);
    send_vector(16'sd0, 16'sd1, 16'sd0);
    send_vector(16'sd0, -16'sd1, 16'sd0);
    send_vector(16'sd0, 16'sd0, 16'sd1);
    send_vector(16'sd0, 16'sd0, -16'sd1);
  endtask

  // Full-scale components, alternating bits, and angles that round to 360
  task automatic test_extremes_and_wrap();
    send_vector(16'sd32767, 16'sd32767, 16'sd32767);
    send_vector(-16'sd32768, -16'sd32768, -16'sd32768);
    send_vector(16'sd32767, -16'sd32768, 16'sd0);
    send_vector(-16'sd32768, 16'sd32767, -16'sd32768);
    send_vector(-16'sd32768, 16'sd0, 16'sd0);
    send_vector(coord_t'(16'h5555), coord_t'(16'hAAAA), coord_t'(16'h5555));
    send_vector(coord_t'(16'hAAAA), coord_t'(16'h5555), coord_t'(16'hAAAA));
    // yaw just under 360
    send_vector(16'sd32767, -16'sd1, 16'sd0);
    // pitch just under 360
    send_vector(16'sd32767, 16'sd0, 16'sd1);
  endtask

  // Vertical detection at the widest tolerance
  task automatic test_vertical_tolerance();
    write_tolerance(8'd255);
    send_vector(16'sd255, -16'sd255, 16'sd7);
    send_vector(-16'sd255, 16'sd255, -16'sd3);
    send_vector(16'sd255, 16'sd255, 16'sd0);
    send_vector(16'sd256, 16'sd0, 16'sd0);
    send_vector(16'sd0, -16'sd256, 16'sd1);
    send_vector(16'sd0, 16'sd0, 16'sd0);
    send_vector(16'sd10, 16'sd5, -16'sd32768);
  endtask

  // Random vectors over several tolerance settings; one stretch with no idling
  task automatic test_random_vectors();
    logic [TOL_W-1:0] phase_tol [6];
    phase_tol = '{8'd0, 8'd255, TOL_W'($urandom), 8'd1, 8'h80, TOL_W'($urandom)};
    for (int p = 0; p < 6; p++) begin
      write_tolerance(phase_tol[p]);
      no_idling = (p == 3);
      for (int n = 0; n < 75; n++) send_vector(coord_sample(), coord_sample(), coord_sample());
    end
    await_idle();
    no_idling = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_null_and_axes();
    test_extremes_and_wrap();
    test_vertical_tolerance();
    test_random_vectors();
    await_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(20_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
